// ===== src/utt_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
package utt_pkg;

  // Largest supported output buffer, in 16-bit units, terminator included.
  localparam int MAX_CAPACITY = 4096;
  localparam int CAP_W        = 13;
  localparam int CNT_W        = $clog2(MAX_CAPACITY + 1);

  // Result queue depth; it must hold at least two entries for a surrogate pair.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Result kinds.
  localparam logic [1:0] KIND_UNIT  = 2'd0;
  localparam logic [1:0] KIND_TERM  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Allowed range of the next continuation byte.
  typedef enum logic [2:0] {
    LC_ANY   = 3'd0,
    LC_A0_BF = 3'd1,
    LC_80_9F = 3'd2,
    LC_90_BF = 3'd3,
    LC_80_8F = 3'd4
  } lead_class_t;

  // One result item.
  typedef struct packed {
    logic [15:0] unit;
    logic [1:0]  kind;
    logic        last;
  } result_t;

  // Results produced by one decoded byte.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== src/utt_decoder.sv =====
// Per-byte UTF-8 decoder: sequence state, validation and UTF-16 unit generation.
`timescale 1ns / 1ps
module utt_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       byte_en,
  input  logic [7:0]                 byte_i,
  input  logic [utt_pkg::CNT_W-1:0]  limit,
  output utt_pkg::push_t             push
);
  import utt_pkg::*;

  logic [1:0]       pending_r, pending_nxt;
  logic [20:0]      accum_r, accum_nxt;
  lead_class_t      lclass_r, lclass_nxt;
  logic [CNT_W-1:0] uw_r, uw_nxt;
  logic             discard_r, discard_nxt;

  // Combinational decode of one byte against the current sequence state.
  always_comb begin
    logic        ok;
    logic [1:0]  pend_dec;
    logic [20:0] acc_new;
    logic [20:0] v;
    logic        fail;

    ok          = 1'b0;
    pend_dec    = pending_r - 2'd1;
    acc_new     = accum_r;
    v           = '0;
    fail        = 1'b0;
    pending_nxt = pending_r;
    accum_nxt   = accum_r;
    lclass_nxt  = lclass_r;
    uw_nxt      = uw_r;
    discard_nxt = discard_r;
    push.cnt    = 2'd0;
    push.r0     = '{unit: 16'h0000, kind: KIND_UNIT, last: 1'b1};
    push.r1     = '{unit: 16'h0000, kind: KIND_UNIT, last: 1'b1};

    if (discard_r) begin
      // Drop everything up to the next zero byte, which restarts silently.
      if (byte_i == 8'h00) begin
        discard_nxt = 1'b0;
        pending_nxt = 2'd0;
        accum_nxt   = '0;
        lclass_nxt  = LC_ANY;
        uw_nxt      = '0;
      end
    end else if (pending_r != 2'd0) begin
      // Continuation byte, with the narrowed range after some lead bytes.
      ok = (byte_i[7:6] == 2'b10);
      case (lclass_r)
        LC_A0_BF: ok = ok && (byte_i >= 8'ha0);
        LC_80_9F: ok = ok && (byte_i <= 8'h9f);
        LC_90_BF: ok = ok && (byte_i >= 8'h90);
        LC_80_8F: ok = ok && (byte_i <= 8'h8f);
        default:  ok = ok;
      endcase
      case (pend_dec)
        2'd2:    acc_new = accum_r | {3'b000, byte_i[5:0], 12'h000};
        2'd1:    acc_new = accum_r | {9'h000, byte_i[5:0], 6'h00};
        default: acc_new = accum_r | {15'h0000, byte_i[5:0]};
      endcase
      v = acc_new - 21'h010000;
      if (!ok) begin
        fail = 1'b1;
      end else if (pend_dec != 2'd0) begin
        pending_nxt = pend_dec;
        accum_nxt   = acc_new;
        lclass_nxt  = LC_ANY;
      end else if (acc_new[20:16] != 5'd0) begin
        // Supplementary plane: a surrogate pair, if two units still fit.
        if (({1'b0, uw_r} + {{CNT_W{1'b0}}, 1'b1} + {{CNT_W{1'b0}}, 1'b1}) >
            {1'b0, limit}) begin
          fail = 1'b1;
        end else begin
          pending_nxt = 2'd0;
          accum_nxt   = '0;
          lclass_nxt  = LC_ANY;
          uw_nxt      = uw_r + CNT_W'(2);
          push.cnt    = 2'd2;
          push.r0     = '{unit: 16'hd800 | {6'b000000, v[19:10]}, kind: KIND_UNIT, last: 1'b0};
          push.r1     = '{unit: 16'hdc00 | {6'b000000, v[9:0]}, kind: KIND_UNIT, last: 1'b1};
        end
      end else begin
        pending_nxt = 2'd0;
        accum_nxt   = '0;
        lclass_nxt  = LC_ANY;
        uw_nxt      = uw_r + CNT_W'(1);
        push.cnt    = 2'd1;
        push.r0     = '{unit: acc_new[15:0], kind: KIND_UNIT, last: 1'b1};
      end
    end else if (byte_i == 8'h00) begin
      // End of string: emit the terminator and start over.
      pending_nxt = 2'd0;
      accum_nxt   = '0;
      lclass_nxt  = LC_ANY;
      uw_nxt      = '0;
      push.cnt    = 2'd1;
      push.r0     = '{unit: 16'h0000, kind: KIND_TERM, last: 1'b1};
    end else if (uw_r >= limit) begin
      fail = 1'b1;
    end else if (byte_i[7] == 1'b0) begin
      // ASCII passes straight through.
      uw_nxt   = uw_r + CNT_W'(1);
      push.cnt = 2'd1;
      push.r0  = '{unit: {8'h00, byte_i}, kind: KIND_UNIT, last: 1'b1};
    end else if (byte_i[7:5] == 3'b110) begin
      // Two-byte lead; C0 and C1 can only encode overlong forms.
      if (byte_i < 8'hc2) begin
        fail = 1'b1;
      end else begin
        accum_nxt   = {10'h000, byte_i[4:0], 6'h00};
        lclass_nxt  = LC_ANY;
        pending_nxt = 2'd1;
      end
    end else if (byte_i[7:4] == 4'b1110) begin
      // Three-byte lead; E0 excludes overlongs and ED excludes surrogates.
      accum_nxt   = {5'h00, byte_i[3:0], 12'h000};
      pending_nxt = 2'd2;
      if (byte_i == 8'he0) begin
        lclass_nxt = LC_A0_BF;
      end else if (byte_i == 8'hed) begin
        lclass_nxt = LC_80_9F;
      end else begin
        lclass_nxt = LC_ANY;
      end
    end else if (byte_i[7:3] == 5'b11110) begin
      // Four-byte lead; F0 excludes overlongs, F4 caps at U+10FFFF.
      if (byte_i > 8'hf4) begin
        fail = 1'b1;
      end else begin
        accum_nxt   = {byte_i[2:0], 18'h00000};
        pending_nxt = 2'd3;
        if (byte_i == 8'hf0) begin
          lclass_nxt = LC_90_BF;
        end else if (byte_i == 8'hf4) begin
          lclass_nxt = LC_80_8F;
        end else begin
          lclass_nxt = LC_ANY;
        end
      end
    end else begin
      fail = 1'b1;
    end

    // A rejected string reports once, then drops bytes unless this was a zero.
    if (fail) begin
      pending_nxt = 2'd0;
      accum_nxt   = '0;
      lclass_nxt  = LC_ANY;
      uw_nxt      = '0;
      discard_nxt = (byte_i != 8'h00);
      push.cnt    = 2'd1;
      push.r0     = '{unit: 16'h0000, kind: KIND_ERROR, last: 1'b1};
    end
  end

  // Sequence state, updated once per decoded byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      accum_r   <= '0;
      lclass_r  <= LC_ANY;
      uw_r      <= '0;
      discard_r <= 1'b0;
    end else if (byte_en) begin
      pending_r <= pending_nxt;
      accum_r   <= accum_nxt;
      lclass_r  <= lclass_nxt;
      uw_r      <= uw_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule

// ===== src/utt_out_queue.sv =====
// Small result queue that takes up to two results per cycle and gives one per cycle while out_ready is high.
`timescale 1ns / 1ps
module utt_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  utt_pkg::push_t   push,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output utt_pkg::result_t out_res
);
  import utt_pkg::*;

  result_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt;
  logic [Q_PTR_W-1:0] rd_r, rd_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [Q_PTR_W-1:0] wr_p1;
  logic               pop;

  // Room for a full surrogate pair is required before a byte is decoded.
  assign space_ok  = (cnt_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign wr_p1     = wr_r + Q_PTR_W'(1);

  // Pointer and occupancy update.
  always_comb begin
    wr_nxt  = wr_r + Q_PTR_W'(push.cnt);
    rd_nxt  = pop ? rd_r + Q_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage; the second result of a pair goes one slot further.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_p1] <= push.r1;
    end
  end

endmodule

// ===== src/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
// The block accepts one UTF-8 byte per cycle on the in_ channel while in_ready
// is high and returns UTF-16 code units, terminators and error reports on the
// out_ channel, one result per cycle while out_ready is high. Each accepted
// byte is held in an input register and then decoded in a single pass into a
// four-entry result queue, and its first result leaves out_ from that queue. A
// byte ending a four-byte sequence yields a surrogate pair that leaves as two
// results; the queue absorbs it, and the input keeps taking a byte every cycle
// as long as the out_ side takes a result every cycle. cfg_capacity sets the
// output buffer size (terminator included) and is always ready; write it only
// between strings while the block is idle.
module utf8_to_utf16_transcoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               out_unit,
  output logic [1:0]                out_kind,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [utt_pkg::CAP_W-1:0] cfg_capacity
);
  import utt_pkg::*;

  logic [7:0]       byte_r;
  logic             byte_vld_r, byte_vld_nxt;
  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic             space_ok;
  logic             advance;
  logic             in_acc;
  push_t            push;
  push_t            push_gated;
  result_t          out_res;

  assign cfg_ready = 1'b1;

  // The held byte is decoded when the queue can take a surrogate pair.
  assign advance      = byte_vld_r && space_ok;
  assign in_ready     = !byte_vld_r || advance;
  assign in_acc       = in_valid && in_ready;
  assign byte_vld_nxt = in_acc || (byte_vld_r && !advance);

  // Unit limit derived from the written capacity, clamped to the supported range.
  always_comb begin
    if ({{(32 - CAP_W){1'b0}}, cfg_capacity} > 32'(MAX_CAPACITY)) begin
      limit_nxt = CNT_W'(MAX_CAPACITY - 1);
    end else if (cfg_capacity == '0) begin
      limit_nxt = '0;
    end else begin
      limit_nxt = CNT_W'(cfg_capacity) - CNT_W'(1);
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      limit_r    <= CNT_W'(MAX_CAPACITY - 1);
    end else begin
      byte_vld_r <= byte_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= limit_nxt;
      end
    end
  end

  // Input byte register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_byte;
    end
  end

  utt_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (advance),
    .byte_i  (byte_r),
    .limit   (limit_r),
    .push    (push)
  );

  // Results are only pushed for a byte that is actually decoded.
  always_comb begin
    push_gated     = push;
    push_gated.cnt = advance ? push.cnt : 2'd0;
  end

  utt_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_gated),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_unit = out_res.unit;
  assign out_kind = out_res.kind;
  assign out_last = out_res.last;

endmodule

// ===== src/utt_checker.sv =====
// Port-level checks for the UTF-8 to UTF-16 transcoder, bound to the top level.
`timescale 1ns / 1ps
module utt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_unit,
  input logic [1:0]  out_kind,
  input logic        out_last
);
  import utt_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unit) && $stable(out_kind)
      && $stable(out_last))
    else $error("result changed while stalled");

  // Only the first half of a surrogate pair is not the last result of its byte.
  a_high_surr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_kind == KIND_UNIT && out_unit[15:10] == 6'b110110)
    else $error("non-final result is not a high surrogate");

  // The low surrogate is queued with the high one and follows without a gap.
  a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last
      && out_kind == KIND_UNIT && out_unit[15:10] == 6'b110111)
    else $error("low surrogate missing after high surrogate");

  // Terminators and error reports carry a zero unit and close their byte.
  a_ctrl_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TERM || out_kind == KIND_ERROR)
      |-> out_unit == 16'h0000 && out_last)
    else $error("terminator or error result malformed");

endmodule

bind utf8_to_utf16_transcoder utt_checker u_utt_checker (.*);
